/* design/i2rd_pkg.sv */
// Package for the integer to radix digits unit.
// Holds default sizes, digit encoding constants, the controller/datapath
// command and status types, and the shared helper functions. No dependencies.
package i2rd_pkg;

    localparam int I2RD_VALUE_WIDTH = 31;
    localparam int I2RD_MAX_DIGITS  = 32;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [DIGIT_W-1:0] DIGIT_LIMIT   = 6'd9;
    localparam logic [CHAR_W-1:0]  LETTER_OFFSET = 7'd55;
    localparam logic [CHAR_W-1:0]  ZERO_CHAR     = 7'd48;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;       // load value and radix, begin the first division
        logic step;        // one restoring division step
        logic store;       // write remainder, prepare the next division
        logic rd;          // read the digit store at the read pointer
        logic load_digit;  // move the read digit into the output register
        logic load_err;    // put the bad radix result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic radix_ok;    // radix on the input port lies in 2..36
        logic div_last;    // this step is the final bit of the division
        logic conv_end;    // quotient reached zero or the store is full
        logic is_last;     // read pointer is at the least significant digit
        logic slot_free;   // output register can take a result this cycle
    } sts_t;

    function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
        logic ok;
        ok = r inside {[RADIX_MIN:RADIX_MAX]};
        return ok;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_LIMIT)
        begin
            c = {1'b0, d} + LETTER_OFFSET;
        end
        else
        begin
            c = {1'b0, d} + ZERO_CHAR;
        end
        return c;
    endfunction

endpackage

/* design/i2rd_ctrl.sv */
// Controller state machine for the integer to radix digits unit.
// Sequences division, digit storage and emission; uses i2rd_pkg.
module i2rd_ctrl
    import i2rd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ERR    = 6'b000010,
        ST_DIVIDE = 6'b000100,
        ST_STORE  = 6'b001000,
        ST_READ   = 6'b010000,
        ST_LOAD   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.radix_ok)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                    else
                    begin
                        state_next = ST_ERR;
                    end
                end
            end
            ST_ERR:
            begin
                if (sts.slot_free)
                begin
                    cmd.load_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (sts.conv_end)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.slot_free)
                begin
                    cmd.load_digit = 1'b1;
                    if (sts.is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A result is only ever written into a free output register.
    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_digit || cmd.load_err) |-> sts.slot_free)
        else $error("output register loaded while still occupied");

    // A remainder is stored only right after a division has run.
    a_store_after_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STORE) |-> ($past(state_reg) == ST_DIVIDE))
        else $error("digit stored without a preceding division");

endmodule

/* design/i2rd_datapath.sv */
// Datapath for the integer to radix digits unit: bit-serial divider,
// digit store memory, counters and the output register. Uses i2rd_pkg.
module i2rd_datapath
    import i2rd_pkg::*;
#(
    parameter int VALUE_WIDTH = I2RD_VALUE_WIDTH,
    parameter int MAX_DIGITS  = I2RD_MAX_DIGITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [RADIX_W-1:0]     radix,
    input  logic                   out_ready,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output logic                   out_valid,
    output logic [DIGIT_W-1:0]     digit_value,
    output logic [CHAR_W-1:0]      digit_char,
    output logic                   last,
    output logic                   bad_radix
);

    localparam int BIT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    // Dividend shifts out at the top while quotient bits enter at the bottom,
    // so after a full pass it holds the quotient.
    logic [VALUE_WIDTH-1:0] quotient_reg, quotient_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [RADIX_W-1:0]     radix_reg;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic                   out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0]     digit_value_reg;
    logic [CHAR_W-1:0]      digit_char_reg;
    logic                   last_reg;
    logic                   bad_radix_reg;
    logic [DIGIT_W-1:0]     rd_data_reg;

    logic [DIGIT_W-1:0]     digit_store [MAX_DIGITS];

    logic [DIGIT_W:0]       trial;
    logic                   trial_ge;
    logic [DIGIT_W:0]       trial_diff;

    assign trial      = {rem_reg, quotient_reg[VALUE_WIDTH-1]};
    assign trial_ge   = (trial >= {1'b0, radix_reg});
    assign trial_diff = trial - {1'b0, radix_reg};

    always_comb
    begin
        quotient_next = quotient_reg;
        rem_next      = rem_reg;
        bit_next      = bit_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        if (cmd.start)
        begin
            quotient_next = value;
            rem_next      = '0;
            bit_next      = '0;
            count_next    = '0;
        end
        else if (cmd.step)
        begin
            quotient_next = {quotient_reg[VALUE_WIDTH-2:0], trial_ge};
            rem_next      = trial_ge ? trial_diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            bit_next      = bit_reg + 1'b1;
        end
        else if (cmd.store)
        begin
            rem_next   = '0;
            bit_next   = '0;
            count_next = count_reg + 1'b1;
            ptr_next   = count_reg[IDX_W-1:0];
        end
        else if (cmd.load_digit && (ptr_reg != '0))
        begin
            ptr_next = ptr_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quotient_reg  <= '0;
            rem_reg       <= '0;
            bit_reg       <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            quotient_reg  <= quotient_next;
            rem_reg       <= rem_next;
            bit_reg       <= bit_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            radix_reg <= radix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            digit_store[count_reg[IDX_W-1:0]] <= rem_reg;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= digit_store[ptr_reg];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_digit || cmd.load_err)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_digit)
        begin
            digit_value_reg <= rd_data_reg;
            digit_char_reg  <= digit_to_char(rd_data_reg);
            last_reg        <= (ptr_reg == '0);
            bad_radix_reg   <= 1'b0;
        end
        else if (cmd.load_err)
        begin
            digit_value_reg <= '0;
            digit_char_reg  <= '0;
            last_reg        <= 1'b1;
            bad_radix_reg   <= 1'b1;
        end
    end

    assign sts.radix_ok  = radix_ok(radix);
    assign sts.div_last  = (bit_reg == BIT_W'(VALUE_WIDTH - 1));
    assign sts.conv_end  = (quotient_reg == '0) || (count_reg == CNT_W'(MAX_DIGITS - 1));
    assign sts.is_last   = (ptr_reg == '0);
    assign sts.slot_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign digit_value = digit_value_reg;
    assign digit_char  = digit_char_reg;
    assign last        = last_reg;
    assign bad_radix   = bad_radix_reg;

    // The partial remainder must stay below the divisor at every step.
    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (rem_reg < radix_reg))
        else $error("partial remainder not below radix");

    // The digit count never passes the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond store depth");

endmodule

/* design/integer_to_radix_digits_unit.sv */
// Integer to radix digits unit converts a non-negative integer into its
// digits in a radix from 2 to 36, delivered most significant digit first,
// one output transfer per digit with the digit value, its ASCII character
// ('0'-'9', then 'A'-'Z'), a last flag on the final digit, and a bad radix
// flag that marks the single result given for a radix outside 2..36. One
// number is converted at a time. Each digit is found in the bit-serial
// restoring divider (one bit per cycle, then the remainder is stored), and
// all digits are then read back one by one from the digit store and loaded
// into the output register. A new number is taken as soon as the last
// digit sits in the output register, even before it is collected.
// Depends on i2rd_pkg, i2rd_ctrl and i2rd_datapath.
module integer_to_radix_digits_unit
    import i2rd_pkg::*;
#(
    parameter int VALUE_WIDTH = I2RD_VALUE_WIDTH,
    parameter int MAX_DIGITS  = I2RD_MAX_DIGITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [RADIX_W-1:0]     radix,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [DIGIT_W-1:0]     digit_value,
    output logic [CHAR_W-1:0]      digit_char,
    output logic                   last,
    output logic                   bad_radix
);

    cmd_t cmd;
    sts_t sts;

    i2rd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    i2rd_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .radix       (radix),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .digit_value (digit_value),
        .digit_char  (digit_char),
        .last        (last),
        .bad_radix   (bad_radix)
    );

endmodule
